@@ hw/rtl/rpw_pkg.sv @@
// Shared types and constants for the robust IRLS weight unit.
`default_nettype none
package rpw_pkg;
	localparam int FRAC_BITS_DEF = 16;
	localparam int U_W           = 32;
	localparam int T_W           = 31;
	localparam int W_OUT         = 17;
	localparam int MODE_W        = 2;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 32;

	localparam logic [CFG_IDX_W-1:0] REG_PSI_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TUNING   = 2'd1;

	localparam logic [MODE_W-1:0] MODE_HUBER  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_HAMPEL = 2'd1;

	localparam logic [T_W-1:0] TUNING_RESET = 31'd88146;

	typedef enum logic [1:0] {
		KIND_ONE,
		KIND_ZERO,
		KIND_QUOT,
		KIND_TUKEY
	} kind_t;

	typedef struct packed {
		logic  valid;
		kind_t kind;
	} ctrl_t;
endpackage
`default_nettype wire

@@ hw/rtl/rpw_front.sv @@
// Front stages: residual magnitude, then region decode and divider operand select.
`default_nettype none
module rpw_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_fire,
	input  logic [rpw_pkg::U_W-1:0]     scaled_residual,
	input  logic [rpw_pkg::MODE_W-1:0]  psi_mode,
	input  logic [rpw_pkg::T_W-1:0]     tuning_constant,
	output rpw_pkg::ctrl_t              ctrl_s2,
	output logic [rpw_pkg::U_W-1:0]     num_s2,
	output logic [rpw_pkg::U_W-1:0]     den_s2
);
	import rpw_pkg::*;

	logic           valid_s1;
	logic [U_W-1:0] mag_s1;
	logic [U_W+1:0] t_x;
	logic [U_W+1:0] m1_x;
	logic [U_W+1:0] m2_x;
	logic [U_W+1:0] m4_x;
	logic [U_W+1:0] diff_x;
	kind_t          kind_d;
	logic [U_W-1:0] num_d;
	logic [U_W-1:0] den_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1 <= scaled_residual[U_W-1] ? (~scaled_residual + 1'b1) : scaled_residual;
		end
	end

	assign t_x    = (U_W+2)'(tuning_constant);
	assign m1_x   = {2'b00, mag_s1};
	assign m2_x   = {1'b0, mag_s1, 1'b0};
	assign m4_x   = {mag_s1, 2'b00};
	assign diff_x = t_x - m1_x;

	always_comb begin
		kind_d = KIND_ZERO;
		num_d  = '0;
		den_d  = '0;
		case (psi_mode)
			MODE_HUBER: begin
				if (m1_x <= t_x) begin
					kind_d = KIND_ONE;
				end else begin
					kind_d = KIND_QUOT;
					num_d  = U_W'(tuning_constant);
					den_d  = mag_s1;
				end
			end
			MODE_HAMPEL: begin
				if (m4_x <= t_x) begin
					kind_d = KIND_ONE;
				end else if (m2_x <= t_x) begin
					kind_d = KIND_QUOT;
					num_d  = U_W'(tuning_constant);
					den_d  = m4_x[U_W-1:0];
				end else if (m1_x <= t_x) begin
					kind_d = KIND_QUOT;
					num_d  = diff_x[U_W-1:0];
					den_d  = m2_x[U_W-1:0];
				end else begin
					kind_d = KIND_ZERO;
				end
			end
			default: begin
				if (m1_x < t_x) begin
					kind_d = KIND_TUKEY;
					num_d  = mag_s1;
					den_d  = U_W'(tuning_constant);
				end else begin
					kind_d = KIND_ZERO;
				end
			end
		endcase
		if (mag_s1 == '0) begin
			kind_d = KIND_ONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s2 <= '0;
		end else if (en) begin
			ctrl_s2.valid <= valid_s1;
			ctrl_s2.kind  <= kind_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s2 <= num_d;
			den_s2 <= den_d;
		end
	end
endmodule
`default_nettype wire

@@ hw/rtl/rpw_div_step.sv @@
// One restoring-division stage: retires one quotient bit per cycle while en is high.
`default_nettype none
module rpw_div_step #(
	parameter int QUOT_W = rpw_pkg::FRAC_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  rpw_pkg::ctrl_t          ctrl_i,
	input  logic [rpw_pkg::U_W-1:0] rem_i,
	input  logic [rpw_pkg::U_W-1:0] den_i,
	input  logic [QUOT_W-1:0]       quot_i,
	output rpw_pkg::ctrl_t          ctrl_s1,
	output logic [rpw_pkg::U_W-1:0] rem_s1,
	output logic [rpw_pkg::U_W-1:0] den_s1,
	output logic [QUOT_W-1:0]       quot_s1
);
	import rpw_pkg::*;

	logic [U_W:0] rem2;
	logic [U_W:0] den_x;
	logic [U_W:0] sub;
	logic         ge;

	assign rem2  = {rem_i, 1'b0};
	assign den_x = {1'b0, den_i};
	assign sub   = rem2 - den_x;
	assign ge    = (rem2 >= den_x);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else if (en) begin
			ctrl_s1 <= ctrl_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s1  <= ge ? sub[U_W-1:0] : rem2[U_W-1:0];
			den_s1  <= den_i;
			quot_s1 <= {quot_i[QUOT_W-2:0], ge};
		end
	end
endmodule
`default_nettype wire

@@ hw/rtl/rpw_post.sv @@
// Back stages: bisquare squarings and final weight select.
`default_nettype none
module rpw_post #(
	parameter int FRAC_BITS = rpw_pkg::FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  rpw_pkg::ctrl_t       ctrl_i,
	input  logic [FRAC_BITS-1:0] quot_i,
	output rpw_pkg::ctrl_t       ctrl_s3,
	output logic [FRAC_BITS:0]   w_s3
);
	import rpw_pkg::*;

	localparam int SQ_W = 2 * FRAC_BITS;
	localparam int SS_W = 2 * FRAC_BITS + 2;
	localparam logic [FRAC_BITS:0] ONE_V = {1'b1, {FRAC_BITS{1'b0}}};

	ctrl_t                ctrl_s1;
	ctrl_t                ctrl_s2;
	logic [FRAC_BITS-1:0] quot_s1;
	logic [FRAC_BITS-1:0] quot_s2;
	logic [SQ_W-1:0]      sq_s1;
	logic [SS_W-1:0]      ss_s2;
	logic [FRAC_BITS:0]   s_c;
	logic [FRAC_BITS:0]   w_d;

	assign s_c = ONE_V - {1'b0, sq_s1[SQ_W-1:FRAC_BITS]};

	always_comb begin
		case (ctrl_s2.kind)
			KIND_ONE:  w_d = ONE_V;
			KIND_ZERO: w_d = '0;
			KIND_QUOT: w_d = {1'b0, quot_s2};
			default:   w_d = ss_s2[2*FRAC_BITS:FRAC_BITS];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
			ctrl_s2 <= '0;
			ctrl_s3 <= '0;
		end else if (en) begin
			ctrl_s1 <= ctrl_i;
			ctrl_s2 <= ctrl_s1;
			ctrl_s3 <= ctrl_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quot_s1 <= quot_i;
			sq_s1   <= SQ_W'(quot_i) * SQ_W'(quot_i);
			quot_s2 <= quot_s1;
			ss_s2   <= SS_W'(s_c) * SS_W'(s_c);
			w_s3    <= w_d;
		end
	end
endmodule
`default_nettype wire

@@ hw/rtl/rpw_skid.sv @@
// Output register with one skid entry so the pipeline keeps moving while a beat waits.
`default_nettype none
module rpw_skid #(
	parameter int DATA_W = rpw_pkg::FRAC_BITS_DEF + 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	input  logic [DATA_W-1:0] push_data,
	output logic              space,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [DATA_W-1:0] out_data
);
	logic              skid_valid_q;
	logic [DATA_W-1:0] skid_data_q;
	logic              push;
	logic              pop_ok;

	assign space  = ~skid_valid_q;
	assign push   = push_valid & space;
	assign pop_ok = ~out_valid | out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid    <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop_ok) begin
			out_valid    <= skid_valid_q | push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop_ok) begin
			out_data <= skid_valid_q ? skid_data_q : push_data;
		end else if (push) begin
			skid_data_q <= push_data;
		end
	end
endmodule
`default_nettype wire

@@ hw/rtl/robust_psi_weight_unit.sv @@
// Robust IRLS weight unit: Huber, Hampel or Tukey bisquare weight of a scaled residual.
//
// Input channel in_valid/in_ready carries one signed Q16.16 scaled_residual per beat.
// Output channel out_valid/out_ready returns one Q1.16 weight per input beat, in order.
// Config channel cfg_valid/cfg_ready writes psi_mode (index 0) or tuning_constant
// (index 1) from cfg_data; other indexes are ignored; cfg_ready is always high.
// Write config only while no beat is in flight.
// Throughput: one beat per cycle while in_ready is high. An accepted beat passes two
// front stages, one divider stage per quotient bit, three back stages (two squarings
// and the select) and the output register. The restoring divider, one quotient bit
// per stage, sets the depth.
// Reset clears all valid bits, psi_mode to Huber and tuning_constant to 1.345.
// When the receiver stalls, one more beat lands in the skid entry; then in_ready
// drops and the whole pipeline holds until the output beat is taken.
`default_nettype none
module robust_psi_weight_unit #(
	parameter int FRAC_BITS = rpw_pkg::FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [rpw_pkg::U_W-1:0] scaled_residual,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [rpw_pkg::W_OUT-1:0]      weight,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [rpw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rpw_pkg::CFG_DATA_W-1:0] cfg_data
);
	import rpw_pkg::*;

	logic [MODE_W-1:0]    psi_mode_q;
	logic [T_W-1:0]       tuning_q;
	logic                 pipe_en;
	logic                 in_fire;
	ctrl_t                dctrl [0:FRAC_BITS];
	logic [U_W-1:0]       drem  [0:FRAC_BITS];
	logic [U_W-1:0]       dden  [0:FRAC_BITS];
	logic [FRAC_BITS-1:0] dquot [0:FRAC_BITS];
	ctrl_t                post_ctrl;
	logic [FRAC_BITS:0]   post_w;
	logic [FRAC_BITS:0]   out_w;

	assign cfg_ready = 1'b1;
	assign in_ready  = pipe_en;
	assign in_fire   = in_valid & pipe_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			psi_mode_q <= MODE_HUBER;
			tuning_q   <= TUNING_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_PSI_MODE: psi_mode_q <= cfg_data[MODE_W-1:0];
				REG_TUNING:   tuning_q   <= cfg_data[T_W-1:0];
				default:      ;
			endcase
		end
	end

	rpw_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.en              (pipe_en),
		.in_fire         (in_fire),
		.scaled_residual (scaled_residual),
		.psi_mode        (psi_mode_q),
		.tuning_constant (tuning_q),
		.ctrl_s2         (dctrl[0]),
		.num_s2          (drem[0]),
		.den_s2          (dden[0])
	);

	assign dquot[0] = '0;

	for (genvar i = 0; i < FRAC_BITS; i++) begin : g_div
		rpw_div_step #(
			.QUOT_W (FRAC_BITS)
		) u_step (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (pipe_en),
			.ctrl_i  (dctrl[i]),
			.rem_i   (drem[i]),
			.den_i   (dden[i]),
			.quot_i  (dquot[i]),
			.ctrl_s1 (dctrl[i+1]),
			.rem_s1  (drem[i+1]),
			.den_s1  (dden[i+1]),
			.quot_s1 (dquot[i+1])
		);
	end

	rpw_post #(
		.FRAC_BITS (FRAC_BITS)
	) u_post (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (pipe_en),
		.ctrl_i  (dctrl[FRAC_BITS]),
		.quot_i  (dquot[FRAC_BITS]),
		.ctrl_s3 (post_ctrl),
		.w_s3    (post_w)
	);

	rpw_skid #(
		.DATA_W (FRAC_BITS + 1)
	) u_skid (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (post_ctrl.valid),
		.push_data  (post_w),
		.space      (pipe_en),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_w)
	);

	assign weight = W_OUT'(out_w);

	a_hold_has_output: assert property (@(posedge clk) disable iff (!arst_n)
		!pipe_en |-> out_valid)
		else $error("pipeline held with no output beat pending");

	a_hold_after_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!pipe_en |-> $past(out_valid && !out_ready))
		else $error("input refused without a preceding output stall");

	a_stall_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready && !pipe_en) |=> out_valid && !in_ready || out_valid)
		else $error("output beat lost while skid entry was full");
endmodule
`default_nettype wire

@@ bench/robust_psi_weight_unit_tb.sv @@
// Self-checking bench for the robust IRLS weight unit: directed table, then random phases.
`default_nettype none
module robust_psi_weight_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import rpw_pkg::*;

	localparam int FRAC = FRAC_BITS_DEF;
	localparam logic [63:0] ONE_W = 64'd1 << FRAC;
	localparam logic [MODE_W-1:0] MODE_TUKEY = 2'd2;
	localparam logic [MODE_W-1:0] MODE_TUKEY_ALT = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
	localparam logic [T_W-1:0] TUNING_MAX = 31'h7FFF_FFFF;
	localparam int DRAIN_CYCLES = FRAC_BITS_DEF + 6 + 10;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 175;
	localparam int CYCLE_LIMIT = 1_000_000;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [T_W-1:0]    tune;
		logic [U_W-1:0]    resid;
		logic              typed;
		logic [W_OUT-1:0]  want;
	} stim_row_t;

	typedef struct packed {
		logic [U_W-1:0]   resid;
		logic [W_OUT-1:0] weight;
	} weight_exp_t;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic [U_W-1:0]        scaled_residual;
	logic                  out_valid;
	logic                  out_ready;
	logic [W_OUT-1:0]      weight;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	weight_exp_t pending_weights[$];
	weight_exp_t head;
	stim_row_t   stim_rows[$];
	logic [MODE_W-1:0] cur_mode;
	logic [T_W-1:0]    cur_tune;
	bit  quiet;
	bit  long_hold_req;
	int  stall_left;
	int  mismatch_count;
	int  weights_checked;
	int  residuals_sent;
	int  settings_used;
	int  cycle_count;

	robust_psi_weight_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.scaled_residual(scaled_residual),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.weight(weight),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	function automatic logic [W_OUT-1:0] irls_weight(logic [MODE_W-1:0] mode,
			logic [T_W-1:0] tune, logic [U_W-1:0] resid);
		logic [63:0] a;
		logic [63:0] t;
		logic [63:0] r;
		logic [63:0] s;
		logic [63:0] w;
		t = {33'd0, tune};
		a = resid[U_W-1] ? (64'h1_0000_0000 - {32'd0, resid}) : {32'd0, resid};
		if (a == 0) begin
			w = ONE_W;
		end else if (mode == MODE_HUBER) begin
			w = (a <= t) ? ONE_W : (t << FRAC) / a;
		end else if (mode == MODE_HAMPEL) begin
			if (4 * a <= t)
				w = ONE_W;
			else if (2 * a <= t)
				w = (t << (FRAC - 2)) / a;
			else if (a <= t)
				w = ((t - a) << (FRAC - 1)) / a;
			else
				w = 0;
		end else begin
			if (a >= t) begin
				w = 0;
			end else begin
				r = (a << FRAC) / t;
				s = ONE_W - ((r * r) >> FRAC);
				w = (s * s) >> FRAC;
			end
		end
		return w[W_OUT-1:0];
	endfunction

	function automatic int gap_len();
		int pick;
		pick = $urandom_range(0, 99);
		if (quiet || pick < 60)
			return 0;
		if (pick < 90)
			return $urandom_range(1, 3);
		if (pick < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic logic [U_W-1:0] pick_residual(logic [T_W-1:0] tune);
		longint mag;
		longint t;
		int unsigned span;
		logic [63:0] neg;
		t = longint'(tune);
		span = 32'(2 * t);
		case ($urandom_range(0, 9))
			0: mag = 0;
			1: mag = t + longint'($urandom_range(0, 6)) - 3;
			2: mag = t / 2 + longint'($urandom_range(0, 6)) - 3;
			3: mag = t / 4 + longint'($urandom_range(0, 6)) - 3;
			4: return $urandom();
			5: begin
				case ($urandom_range(0, 3))
					0: return 32'h7FFF_FFFF;
					1: return 32'h8000_0000;
					2: return 32'h0000_0001;
					default: return 32'hFFFF_FFFF;
				endcase
			end
			6, 7: mag = longint'($urandom_range(0, span));
			default: mag = longint'($urandom_range(0, {1'b0, tune}));
		endcase
		if (mag < 0)
			mag = 0;
		if (mag > 64'h8000_0000)
			mag = 64'h8000_0000;
		if ($urandom_range(0, 1) == 1) begin
			neg = -mag;
			return neg[U_W-1:0];
		end
		if (mag == 64'h8000_0000)
			mag = 64'h7FFF_FFFF;
		return mag[U_W-1:0];
	endfunction

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_PSI_MODE)
			cur_mode = data[MODE_W-1:0];
		else if (idx == REG_TUNING)
			cur_tune = data[T_W-1:0];
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_weights.size() != 0)
			@(posedge clk);
	endtask

	task automatic apply_settings(logic [MODE_W-1:0] mode, logic [CFG_DATA_W-1:0] tune_data);
		logic [CFG_DATA_W-1:0] mode_data;
		mode_data = $urandom();
		mode_data[MODE_W-1:0] = mode;
		wait_drained();
		write_reg(REG_PSI_MODE, mode_data);
		write_reg(REG_TUNING, tune_data);
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	task automatic send_residual(logic [U_W-1:0] resid, logic typed, logic [W_OUT-1:0] want);
		int gap;
		weight_exp_t item;
		gap = gap_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		scaled_residual <= resid;
		do @(posedge clk); while (!in_ready);
		item.resid = resid;
		item.weight = typed ? want : irls_weight(cur_mode, cur_tune, resid);
		pending_weights.push_back(item);
		residuals_sent++;
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d weights outstanding", $time,
				pending_weights.size());
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		out_ready = 1'b0;
		stall_left = 0;
		@(posedge arst_n);
		forever @(posedge clk) begin
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else if (long_hold_req) begin
				out_ready <= 1'b0;
				stall_left = HOLD_CYCLES - 1;
				long_hold_req = 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (!quiet && $urandom_range(0, 99) < 20)
					stall_left = 1 + gap_len();
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_weights.size() == 0) begin
				$display("%0t: weight %0d arrived with nothing expected", $time, weight);
				mismatch_count++;
			end else begin
				head = pending_weights.pop_front();
				if (weight !== head.weight) begin
					$display("%0t: residual %h: expected weight %0d, actual %0d",
						$time, head.resid, head.weight, weight);
					mismatch_count++;
				end
				weights_checked++;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		scaled_residual = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		quiet = 1'b0;
		long_hold_req = 1'b0;
		mismatch_count = 0;
		weights_checked = 0;
		residuals_sent = 0;
		settings_used = 1;
		cycle_count = 0;
		cur_mode = MODE_HUBER;
		cur_tune = TUNING_RESET;
		stim_rows = '{
			'{MODE_HUBER, TUNING_RESET, 32'h0000_0000, 1'b1, 17'd65536},
			'{MODE_HUBER, TUNING_RESET, 32'h0001_5852, 1'b1, 17'd65536},
			'{MODE_HUBER, TUNING_RESET, 32'h0001_5853, 1'b0, 17'd0},
			'{MODE_HUBER, TUNING_RESET, 32'h7FFF_FFFF, 1'b1, 17'd2},
			'{MODE_HUBER, TUNING_RESET, 32'h8000_0000, 1'b1, 17'd2},
			'{MODE_HUBER, TUNING_RESET, 32'h0000_0001, 1'b1, 17'd65536},
			'{MODE_HUBER, TUNING_MAX, 32'h8000_0000, 1'b1, 17'd65535},
			'{MODE_HAMPEL, 31'd262144, 32'h0001_0000, 1'b1, 17'd65536},
			'{MODE_HAMPEL, 31'd262144, 32'h0001_0001, 1'b0, 17'd0},
			'{MODE_HAMPEL, 31'd262144, 32'h0002_0000, 1'b0, 17'd0},
			'{MODE_HAMPEL, 31'd262144, 32'hFFFC_0000, 1'b1, 17'd0},
			'{MODE_HAMPEL, 31'd262144, 32'h0003_FFFF, 1'b0, 17'd0},
			'{MODE_HAMPEL, 31'd262144, 32'h8000_0000, 1'b1, 17'd0},
			'{MODE_TUKEY, 31'd307036, 32'h0004_AF5C, 1'b1, 17'd0},
			'{MODE_TUKEY, 31'd307036, 32'h0004_AF5B, 1'b0, 17'd0},
			'{MODE_TUKEY, 31'd307036, 32'h0001_86A0, 1'b0, 17'd0},
			'{MODE_TUKEY, 31'd307036, 32'hFFFF_FFFF, 1'b0, 17'd0},
			'{MODE_TUKEY, 31'd307036, 32'h0000_0000, 1'b1, 17'd65536},
			'{MODE_TUKEY_ALT, 31'd1, 32'h0000_0001, 1'b1, 17'd0},
			'{MODE_TUKEY_ALT, 31'd1, 32'hFFFF_FFFF, 1'b1, 17'd0},
			'{MODE_TUKEY_ALT, TUNING_MAX, 32'h7FFF_FFFE, 1'b0, 17'd0},
			'{MODE_TUKEY_ALT, TUNING_MAX, 32'h8000_0000, 1'b1, 17'd0},
			'{MODE_HAMPEL, 31'd0, 32'h0000_0005, 1'b1, 17'd0},
			'{MODE_HAMPEL, 31'd0, 32'h0000_0000, 1'b1, 17'd65536},
			'{MODE_HUBER, 31'd0, 32'h8000_0000, 1'b1, 17'd0}
		};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_reg(REG_SPARE_A, $urandom());
		write_reg(REG_SPARE_B, $urandom());
		cfg_valid <= 1'b0;

		foreach (stim_rows[i]) begin
			if (stim_rows[i].mode != cur_mode || stim_rows[i].tune != cur_tune)
				apply_settings(stim_rows[i].mode, {1'b0, stim_rows[i].tune});
			send_residual(stim_rows[i].resid, stim_rows[i].typed, stim_rows[i].want);
		end

		for (int p = 0; p < PHASES; p++) begin
			logic [T_W-1:0] tune;
			logic [CFG_DATA_W-1:0] tune_data;
			case ((p + p / 4) % 4)
				0: tune = T_W'($urandom_range(65536, 6 * 65536));
				1: tune = T_W'($urandom_range(1, 64));
				2: tune = TUNING_MAX;
				default: tune = T_W'($urandom());
			endcase
			tune_data = $urandom();
			tune_data[T_W-1:0] = tune;
			apply_settings(MODE_W'(p % 4), tune_data);
			quiet = (p == 5);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (p == 2 && n == 40)
					long_hold_req = 1'b1;
				send_residual(pick_residual(cur_tune), 1'b0, '0);
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_weights.size() != 0)
			mismatch_count++;
		$display("Sent %0d residuals under %0d psi/tuning settings; %0d weights checked.",
			residuals_sent, settings_used, weights_checked);
		$display("Huber, Hampel and both Tukey codes, tuning from 0 to max, long output stall.");
		if (mismatch_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
`default_nettype wire
